// ----- src/oahi_pkg.sv -----
// ----------------------------------------------------------------------------
// oahi_pkg
// Shared types and constants of the open-addressing hash insert unit: command
// and mode codes, register indexes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package oahi_pkg;

	// Width of the statistics counters and of the configuration data bus.
	localparam int CNT_W = 32;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;

	// Commands carried by an input transfer.
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_CHECK  = 2'd2
	} cmd_t;

	// Probe sequences.
	typedef enum logic [1:0] {
		MODE_LINEAR = 2'd0,
		MODE_QUAD   = 2'd1,
		MODE_DOUBLE = 2'd2
	} mode_t;

	// Register indexes on the configuration port (byte address / 4).
	typedef enum logic [1:0] {
		REG_PROBE_MODE   = 2'd0,
		REG_TABLE_SIZE   = 2'd1,
		REG_SECOND_PRIME = 2'd2
	} reg_idx_t;

	// Operand selection of the serial modulo unit.
	typedef enum logic [1:0] {
		MSEL_HOME  = 2'd0,
		MSEL_PRIME = 2'd1,
		MSEL_STEP  = 2'd2
	} mod_sel_t;

	// Kind of result produced at the end of a command.
	typedef enum logic [2:0] {
		RES_NONE   = 3'd0,
		RES_INSERT = 3'd1,
		RES_FAIL   = 3'd2,
		RES_CLEAR  = 3'd3,
		RES_CHECK  = 3'd4
	} res_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_CLR_INIT,
		S_CLR_CMD,
		S_IDLE,
		S_DISP,
		S_MOD_HOME,
		S_MOD_PRIME,
		S_STEP_START,
		S_MOD_STEP,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load_item;
		logic     mod_start;
		mod_sel_t mod_sel;
		logic     take_home;
		logic     take_step_raw;
		logic     take_step;
		logic     ram_rd;
		logic     rd_idx;
		logic     probe_next;
		logic     clr_start;
		logic     clr_write;
		logic     finish;
		res_t     kind;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       mod_done;
		logic       slot_valid;
		logic       last_probe;
		logic       clr_last;
		logic       dbl_ok;
		logic       out_free;
		logic [1:0] cmd_code;
	} dp_status_t;

endpackage

// ----- src/oahi_ram.sv -----
// ----------------------------------------------------------------------------
// oahi_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module oahi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/oahi_mod.sv -----
// ----------------------------------------------------------------------------
// oahi_mod
// Serial restoring modulo unit: one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module oahi_mod #(
	parameter int DW = 31,
	parameter int VW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [VW-1:0] rem
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [VW-1:0] div_q;
	logic [VW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;

	// Shift in the next dividend bit and subtract when it fits.
	always_comb begin
		trial = {rem_q, dvd_q[DW-1]};
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Operand and remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= VW'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[VW-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- src/oahi_dp.sv -----
// ----------------------------------------------------------------------------
// oahi_dp
// Datapath: item registers, modulo unit, probe position arithmetic, slot RAM,
// statistics counters and the result register.
// ----------------------------------------------------------------------------
module oahi_dp #(
	parameter int MAX_SLOTS = 1024,
	parameter int KEY_BITS  = 31
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  oahi_pkg::ctrl_cmd_t            cmd_i,
	output oahi_pkg::dp_status_t           status,
	input  logic [1:0]                     probe_mode,
	input  logic [$clog2(MAX_SLOTS):0]     table_size,
	input  logic [$clog2(MAX_SLOTS)-1:0]   second_prime,
	input  logic [1:0]                     cmd,
	input  logic [KEY_BITS-1:0]            key,
	input  logic [$clog2(MAX_SLOTS)-1:0]   slot_index,
	input  logic                           rsp_stall,
	output logic                           rsp_valid,
	output logic                           inserted,
	output logic                           failed,
	output logic [$clog2(MAX_SLOTS)-1:0]   placed_slot,
	output logic [$clog2(MAX_SLOTS):0]     probes_used,
	output logic                           slot_matches,
	output logic [oahi_pkg::CNT_W-1:0]     total_probes_out,
	output logic [oahi_pkg::CNT_W-1:0]     insert_count_out,
	output logic [oahi_pkg::CNT_W-1:0]     failure_count_out
);

	localparam int SW = $clog2(MAX_SLOTS);
	localparam int DW = (KEY_BITS > SW) ? KEY_BITS : SW;
	localparam int CW = oahi_pkg::CNT_W;

	logic [1:0]          cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [SW-1:0]       idx_q;
	logic [SW-1:0]       pos_q;
	logic [SW-1:0]       step_q;
	logic [SW-1:0]       inc_q;
	logic [SW:0]         t_q;
	logic [SW-1:0]       clr_q;
	logic [CW-1:0]       total_q;
	logic [CW-1:0]       ins_cnt_q;
	logic [CW-1:0]       fail_cnt_q;
	logic                out_valid_q;

	logic [SW:0]         size;
	logic                dbl;
	logic [DW-1:0]       mod_dvd;
	logic [SW:0]         mod_div;
	logic                mod_done;
	logic [SW:0]         mod_rem;
	logic [SW-1:0]       add;
	logic [SW:0]         sum;
	logic [SW-1:0]       pos_next;
	logic [SW:0]         inc_sum;
	logic [SW-1:0]       inc_next;
	logic [SW:0]         used;
	logic [CW:0]         total_sum;
	logic [CW:0]         ins_sum;
	logic [CW:0]         fail_sum;
	logic [CW-1:0]       total_sat;
	logic [CW-1:0]       ins_sat;
	logic [CW-1:0]       fail_sat;
	logic                ram_we;
	logic [SW-1:0]       ram_waddr;
	logic [KEY_BITS:0]   ram_wdata;
	logic [SW-1:0]       ram_raddr;
	logic [KEY_BITS:0]   ram_rdata;
	logic                idx_ok;
	logic                match;

	// Table size in use: zero counts as one, oversize as the full table.
	always_comb begin
		if (table_size == '0) begin
			size = (SW+1)'(1);
		end else if (table_size > (SW+1)'(MAX_SLOTS)) begin
			size = (SW+1)'(MAX_SLOTS);
		end else begin
			size = table_size;
		end
		dbl = (probe_mode == oahi_pkg::MODE_DOUBLE);
	end

	// Operand selection of the modulo unit.
	always_comb begin
		case (cmd_i.mod_sel)
			oahi_pkg::MSEL_PRIME: begin
				mod_dvd = DW'(key_q);
				mod_div = {1'b0, second_prime};
			end
			oahi_pkg::MSEL_STEP: begin
				mod_dvd = DW'(step_q);
				mod_div = size;
			end
			default: begin
				mod_dvd = DW'(key_q);
				mod_div = size;
			end
		endcase
	end

	oahi_mod #(
		.DW (DW),
		.VW (SW + 1)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd_i.mod_start),
		.dividend (mod_dvd),
		.divisor  (mod_div),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Next probe position: add the per-mode increment and wrap once.
	always_comb begin
		case (probe_mode)
			oahi_pkg::MODE_QUAD:   add = inc_q;
			oahi_pkg::MODE_DOUBLE: add = step_q;
			default:               add = SW'(1);
		endcase
		sum = {1'b0, pos_q} + {1'b0, add};
		if (sum >= size) begin
			pos_next = SW'(sum - size);
		end else begin
			pos_next = sum[SW-1:0];
		end
		// Quadratic increment 2t+1 kept reduced modulo the size.
		inc_sum = {1'b0, inc_q} + (SW+1)'(2);
		if (inc_sum >= size) begin
			inc_next = SW'(inc_sum - size);
		end else begin
			inc_next = inc_sum[SW-1:0];
		end
		used = t_q + 1'b1;
	end

	// Saturating counter updates.
	always_comb begin
		total_sum = {1'b0, total_q} + (CW+1)'(used);
		ins_sum   = {1'b0, ins_cnt_q} + (CW+1)'(1);
		fail_sum  = {1'b0, fail_cnt_q} + (CW+1)'(1);
		total_sat = total_sum[CW] ? '1 : total_sum[CW-1:0];
		ins_sat   = ins_sum[CW] ? '1 : ins_sum[CW-1:0];
		fail_sat  = fail_sum[CW] ? '1 : fail_sum[CW-1:0];
	end

	// Slot RAM: valid bit on top of the key; clearing writes zero words.
	always_comb begin
		ram_we    = cmd_i.clr_write ||
		            (cmd_i.finish && cmd_i.kind == oahi_pkg::RES_INSERT);
		ram_waddr = cmd_i.clr_write ? clr_q : pos_q;
		ram_wdata = cmd_i.clr_write ? '0 : {1'b1, key_q};
		ram_raddr = cmd_i.rd_idx ? idx_q : pos_q;
	end

	oahi_ram #(
		.WIDTH (KEY_BITS + 1),
		.DEPTH (MAX_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd_i.ram_rd),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Slot check result.
	always_comb begin
		idx_ok = ({1'b0, idx_q} < (SW+1)'(MAX_SLOTS));
		match  = idx_ok && ram_rdata[KEY_BITS] && (ram_rdata[KEY_BITS-1:0] == key_q);
	end

	// Item and probe registers.
	always_ff @(posedge clk) begin
		if (cmd_i.load_item) begin
			cmd_q <= cmd;
			key_q <= key;
			idx_q <= slot_index;
		end
		if (cmd_i.take_home) begin
			pos_q <= mod_rem[SW-1:0];
			t_q   <= '0;
			inc_q <= SW'(1);
			step_q <= '0;
		end
		if (cmd_i.take_step_raw) begin
			step_q <= second_prime - mod_rem[SW-1:0];
		end
		if (cmd_i.take_step) begin
			step_q <= mod_rem[SW-1:0];
		end
		if (cmd_i.probe_next) begin
			pos_q <= pos_next;
			inc_q <= inc_next;
			t_q   <= used;
		end
	end

	// Clear sweep address and statistics counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			total_q    <= '0;
			ins_cnt_q  <= '0;
			fail_cnt_q <= '0;
		end else begin
			if (cmd_i.clr_start) begin
				clr_q <= '0;
			end else if (cmd_i.clr_write) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd_i.finish) begin
				case (cmd_i.kind)
					oahi_pkg::RES_INSERT: begin
						total_q   <= total_sat;
						ins_cnt_q <= ins_sat;
					end
					oahi_pkg::RES_FAIL: begin
						fail_cnt_q <= fail_sat;
					end
					oahi_pkg::RES_CLEAR: begin
						total_q    <= '0;
						ins_cnt_q  <= '0;
						fail_cnt_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.finish) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded when a command completes.
	always_ff @(posedge clk) begin
		if (cmd_i.finish) begin
			inserted          <= (cmd_i.kind == oahi_pkg::RES_INSERT);
			failed            <= (cmd_i.kind == oahi_pkg::RES_FAIL);
			placed_slot       <= (cmd_i.kind == oahi_pkg::RES_INSERT) ? pos_q : '0;
			probes_used       <= (cmd_i.kind == oahi_pkg::RES_INSERT) ? used : '0;
			slot_matches      <= (cmd_i.kind == oahi_pkg::RES_CHECK) && match;
			total_probes_out  <= total_q;
			insert_count_out  <= ins_cnt_q;
			failure_count_out <= fail_cnt_q;
			case (cmd_i.kind)
				oahi_pkg::RES_INSERT: begin
					total_probes_out <= total_sat;
					insert_count_out <= ins_sat;
				end
				oahi_pkg::RES_FAIL: begin
					failure_count_out <= fail_sat;
				end
				oahi_pkg::RES_CLEAR: begin
					total_probes_out  <= '0;
					insert_count_out  <= '0;
					failure_count_out <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Status toward the controller.
	always_comb begin
		status.mod_done   = mod_done;
		status.slot_valid = ram_rdata[KEY_BITS];
		status.last_probe = (used == size) || (dbl && second_prime == '0);
		status.clr_last   = (clr_q == SW'(MAX_SLOTS - 1));
		status.dbl_ok     = dbl && (second_prime != '0);
		status.out_free   = !out_valid_q || !rsp_stall;
		status.cmd_code   = cmd_q;
	end

	assign rsp_valid = out_valid_q;

endmodule

// ----- src/oahi_ctrl.sv -----
// ----------------------------------------------------------------------------
// oahi_ctrl
// Controller: sequences the clear sweep, the modulo steps, the probe loop and
// the completion of each command.
// ----------------------------------------------------------------------------
module oahi_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  oahi_pkg::dp_status_t  status,
	output oahi_pkg::ctrl_cmd_t   cmd_o
);

	oahi_pkg::state_t state_q;
	oahi_pkg::state_t state_d;
	oahi_pkg::res_t   kind_q;
	oahi_pkg::res_t   kind_d;

	// State and result kind registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oahi_pkg::S_CLR_INIT;
			kind_q  <= oahi_pkg::RES_NONE;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		unique case (state_q)
			oahi_pkg::S_CLR_INIT: begin
				if (status.clr_last) begin
					state_d = oahi_pkg::S_IDLE;
				end
			end
			oahi_pkg::S_CLR_CMD: begin
				if (status.clr_last) begin
					state_d = oahi_pkg::S_FINISH;
					kind_d  = oahi_pkg::RES_CLEAR;
				end
			end
			oahi_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = oahi_pkg::S_DISP;
				end
			end
			oahi_pkg::S_DISP: begin
				unique case (status.cmd_code)
					oahi_pkg::CMD_INSERT: state_d = oahi_pkg::S_MOD_HOME;
					oahi_pkg::CMD_CLEAR:  state_d = oahi_pkg::S_CLR_CMD;
					oahi_pkg::CMD_CHECK: begin
						state_d = oahi_pkg::S_FINISH;
						kind_d  = oahi_pkg::RES_CHECK;
					end
					default: begin
						state_d = oahi_pkg::S_FINISH;
						kind_d  = oahi_pkg::RES_NONE;
					end
				endcase
			end
			oahi_pkg::S_MOD_HOME: begin
				if (status.mod_done) begin
					state_d = status.dbl_ok ? oahi_pkg::S_MOD_PRIME : oahi_pkg::S_PROBE_RD;
				end
			end
			oahi_pkg::S_MOD_PRIME: begin
				if (status.mod_done) begin
					state_d = oahi_pkg::S_STEP_START;
				end
			end
			oahi_pkg::S_STEP_START: state_d = oahi_pkg::S_MOD_STEP;
			oahi_pkg::S_MOD_STEP: begin
				if (status.mod_done) begin
					state_d = oahi_pkg::S_PROBE_RD;
				end
			end
			oahi_pkg::S_PROBE_RD: state_d = oahi_pkg::S_PROBE_CHK;
			oahi_pkg::S_PROBE_CHK: begin
				if (!status.slot_valid) begin
					state_d = oahi_pkg::S_FINISH;
					kind_d  = oahi_pkg::RES_INSERT;
				end else if (status.last_probe) begin
					state_d = oahi_pkg::S_FINISH;
					kind_d  = oahi_pkg::RES_FAIL;
				end else begin
					state_d = oahi_pkg::S_PROBE_RD;
				end
			end
			oahi_pkg::S_FINISH: begin
				if (status.out_free) begin
					state_d = oahi_pkg::S_IDLE;
				end
			end
			default: state_d = oahi_pkg::S_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd_o     = '0;
		req_stall = (state_q != oahi_pkg::S_IDLE);
		unique case (state_q)
			oahi_pkg::S_CLR_INIT, oahi_pkg::S_CLR_CMD: begin
				cmd_o.clr_write = 1'b1;
			end
			oahi_pkg::S_IDLE: begin
				cmd_o.load_item = req_valid;
			end
			oahi_pkg::S_DISP: begin
				unique case (status.cmd_code)
					oahi_pkg::CMD_INSERT: begin
						cmd_o.mod_start = 1'b1;
						cmd_o.mod_sel   = oahi_pkg::MSEL_HOME;
					end
					oahi_pkg::CMD_CLEAR: begin
						cmd_o.clr_start = 1'b1;
					end
					oahi_pkg::CMD_CHECK: begin
						cmd_o.ram_rd = 1'b1;
						cmd_o.rd_idx = 1'b1;
					end
					default: begin
					end
				endcase
			end
			oahi_pkg::S_MOD_HOME: begin
				if (status.mod_done) begin
					cmd_o.take_home = 1'b1;
					cmd_o.mod_start = status.dbl_ok;
					cmd_o.mod_sel   = oahi_pkg::MSEL_PRIME;
				end
			end
			oahi_pkg::S_MOD_PRIME: begin
				cmd_o.mod_sel       = oahi_pkg::MSEL_PRIME;
				cmd_o.take_step_raw = status.mod_done;
			end
			oahi_pkg::S_STEP_START: begin
				cmd_o.mod_start = 1'b1;
				cmd_o.mod_sel   = oahi_pkg::MSEL_STEP;
			end
			oahi_pkg::S_MOD_STEP: begin
				cmd_o.mod_sel   = oahi_pkg::MSEL_STEP;
				cmd_o.take_step = status.mod_done;
			end
			oahi_pkg::S_PROBE_RD: begin
				cmd_o.ram_rd = 1'b1;
			end
			oahi_pkg::S_PROBE_CHK: begin
				cmd_o.probe_next = status.slot_valid && !status.last_probe;
			end
			oahi_pkg::S_FINISH: begin
				cmd_o.finish = status.out_free;
				cmd_o.kind   = kind_q;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- src/open_addressing_hash_insert.sv -----
// ----------------------------------------------------------------------------
// open_addressing_hash_insert
// Open-addressing hash table with linear, quadratic or double-hashing probes,
// a clear command, a slot check command and saturating statistics counters.
//
//   channel   handshake             payload
//   req       req_valid/req_stall   cmd, key, slot_index
//   rsp       rsp_valid/rsp_stall   inserted .. failure_count_out
//   config    APB psel/penable      probe_mode, table_size, second_prime
//
// An insert runs the serial modulo for the home slot, plus the modulo by the
// second prime and the step modulo in double-hashing mode, then one slot RAM
// read and a check per probe, and completes in the finish state. A check
// reads the slot RAM once. A clear sweeps the slot RAM one entry a cycle; the
// same sweep runs after reset, during which req_stall is high.
// One command is worked at a time; the result register frees the block for
// the next transfer while the last result waits on rsp_stall.
// ----------------------------------------------------------------------------
module open_addressing_hash_insert #(
	parameter int MAX_SLOTS = 1024,
	parameter int KEY_BITS  = 31
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [oahi_pkg::ADDR_W-1:0]        paddr,
	input  logic [oahi_pkg::DATA_W-1:0]        pwdata,
	output logic [oahi_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	// Request channel
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [1:0]                         cmd,
	input  logic [KEY_BITS-1:0]                key,
	input  logic [$clog2(MAX_SLOTS)-1:0]       slot_index,
	// Response channel
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic                               inserted,
	output logic                               failed,
	output logic [$clog2(MAX_SLOTS)-1:0]       placed_slot,
	output logic [$clog2(MAX_SLOTS):0]         probes_used,
	output logic                               slot_matches,
	output logic [oahi_pkg::CNT_W-1:0]         total_probes_out,
	output logic [oahi_pkg::CNT_W-1:0]         insert_count_out,
	output logic [oahi_pkg::CNT_W-1:0]         failure_count_out
);

	localparam int SW = $clog2(MAX_SLOTS);

	logic [1:0]    probe_mode_q;
	logic [SW:0]   table_size_q;
	logic [SW-1:0] second_prime_q;
	logic          cfg_wr;
	logic [1:0]    reg_idx;

	oahi_pkg::ctrl_cmd_t  dp_cmd;
	oahi_pkg::dp_status_t dp_status;

	// Register decode.
	always_comb begin
		cfg_wr  = psel && penable && pwrite;
		reg_idx = paddr[3:2];
		pready  = 1'b1;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_mode_q   <= 2'(oahi_pkg::MODE_LINEAR);
			table_size_q   <= (SW+1)'(1021);
			second_prime_q <= SW'(1019);
		end else if (cfg_wr && paddr[1:0] == 2'b00) begin
			unique case (reg_idx)
				oahi_pkg::REG_PROBE_MODE:   probe_mode_q   <= pwdata[1:0];
				oahi_pkg::REG_TABLE_SIZE:   table_size_q   <= pwdata[SW:0];
				oahi_pkg::REG_SECOND_PRIME: second_prime_q <= pwdata[SW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (reg_idx)
				oahi_pkg::REG_PROBE_MODE:   prdata = oahi_pkg::DATA_W'(probe_mode_q);
				oahi_pkg::REG_TABLE_SIZE:   prdata = oahi_pkg::DATA_W'(table_size_q);
				oahi_pkg::REG_SECOND_PRIME: prdata = oahi_pkg::DATA_W'(second_prime_q);
				default:                    prdata = '0;
			endcase
		end
	end

	oahi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (dp_status),
		.cmd_o     (dp_cmd)
	);

	oahi_dp #(
		.MAX_SLOTS (MAX_SLOTS),
		.KEY_BITS  (KEY_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd_i             (dp_cmd),
		.status            (dp_status),
		.probe_mode        (probe_mode_q),
		.table_size        (table_size_q),
		.second_prime      (second_prime_q),
		.cmd               (cmd),
		.key               (key),
		.slot_index        (slot_index),
		.rsp_stall         (rsp_stall),
		.rsp_valid         (rsp_valid),
		.inserted          (inserted),
		.failed            (failed),
		.placed_slot       (placed_slot),
		.probes_used       (probes_used),
		.slot_matches      (slot_matches),
		.total_probes_out  (total_probes_out),
		.insert_count_out  (insert_count_out),
		.failure_count_out (failure_count_out)
	);

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the open-addressing hash insert unit. A directed
// table exercises probe wraparound, checks, the ignored command and clear.
// Random phases then run each probe mode over several table sizes and primes,
// extremes included. Each result is compared with its table row or an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 1024;
	localparam int KB = 31;
	localparam logic [1:0] CMD_IGNORED = 2'd3;
	localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;
	localparam int IDLE_LIMIT = 50000;

	typedef struct packed {
		logic        ins;
		logic        fail;
		logic [9:0]  slot;
		logic [10:0] probes;
		logic        match;
		logic [31:0] tot;
		logic [31:0] icnt;
		logic [31:0] fcnt;
	} table_result_t;

	typedef struct {
		logic [1:0]    c;
		logic [30:0]   k;
		logic [9:0]    idx;
		bit            typed;
		table_result_t res;
	} dir_row_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [oahi_pkg::ADDR_W-1:0] paddr = '0;
	logic [oahi_pkg::DATA_W-1:0] pwdata = '0;
	logic [oahi_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 0, req_stall;
	logic [1:0] cmd = '0;
	logic [KB-1:0] key = '0;
	logic [9:0] slot_index = '0;
	logic rsp_valid, rsp_stall = 0;
	logic inserted, failed, slot_matches;
	logic [9:0] placed_slot;
	logic [10:0] probes_used;
	logic [31:0] total_probes_out, insert_count_out, failure_count_out;

	open_addressing_hash_insert dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Model state of the table and its registers.
	logic [1:0]  m_mode = 2'd0;
	logic [10:0] m_size = 11'd1021;
	logic [9:0]  m_prime = 10'd1019;
	logic [30:0] m_keys [SLOTS];
	bit          m_valid [SLOTS];
	logic [31:0] m_tot = 0, m_icnt = 0, m_fcnt = 0;

	table_result_t pending_q[$];
	int errors = 0;
	int n_ins = 0, n_fail = 0, n_chk = 0, n_clr = 0;
	int idle_cycles = 0;
	int stall_pct = 0;

	function automatic logic [31:0] sat_inc(logic [31:0] a, longint b);
		longint s;
		s = longint'(a) + b;
		return (s > longint'(CNT_SAT)) ? CNT_SAT : s[31:0];
	endfunction

	// Applies one command to the model and returns the result it produces.
	function automatic table_result_t apply_command(logic [1:0] c, logic [30:0] k,
			logic [9:0] idx);
		table_result_t r;
		longint size, home, step, off, pos;
		bit dbl, done;
		r = '0;
		done = 0;
		if (c == oahi_pkg::CMD_INSERT) begin
			size = (m_size == 0) ? 1 : (m_size > SLOTS) ? SLOTS : m_size;
			home = longint'(k) % size;
			dbl = (m_mode == oahi_pkg::MODE_DOUBLE);
			step = 0;
			if (dbl && m_prime != 0)
				step = m_prime - (longint'(k) % m_prime);
			for (longint t = 0; t < size; t++) begin
				if (dbl) begin
					if (t > 0 && m_prime == 0) break;
					off = t * step;
				end else if (m_mode == oahi_pkg::MODE_QUAD) begin
					off = t * t;
				end else begin
					off = t;
				end
				pos = (home + off) % size;
				if (!m_valid[pos]) begin
					m_valid[pos] = 1;
					m_keys[pos] = k;
					r.ins = 1;
					r.slot = pos[9:0];
					r.probes = 11'(t + 1);
					m_tot = sat_inc(m_tot, t + 1);
					m_icnt = sat_inc(m_icnt, 1);
					done = 1;
					break;
				end
			end
			if (!done) begin
				r.fail = 1;
				m_fcnt = sat_inc(m_fcnt, 1);
			end
		end else if (c == oahi_pkg::CMD_CLEAR) begin
			foreach (m_valid[i]) m_valid[i] = 0;
			m_tot = 0;
			m_icnt = 0;
			m_fcnt = 0;
		end else if (c == oahi_pkg::CMD_CHECK) begin
			r.match = m_valid[idx] && (m_keys[idx] == k);
		end
		r.tot = m_tot;
		r.icnt = m_icnt;
		r.fcnt = m_fcnt;
		return r;
	endfunction

	// Response checker: every transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		table_result_t got, want;
		if (rsp_valid && !rsp_stall) begin
			got = {inserted, failed, placed_slot, probes_used, slot_matches,
				total_probes_out, insert_count_out, failure_count_out};
			if (pending_q.size() == 0) begin
				errors++;
				$display("%t unexpected response %h", $realtime, got);
			end else begin
				want = pending_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%t mismatch: expected ins=%0d fail=%0d slot=%0d probes=%0d",
						$realtime, want.ins, want.fail, want.slot, want.probes);
					$display("   match=%0d tot=%0d icnt=%0d fcnt=%0d", want.match,
						want.tot, want.icnt, want.fcnt);
					$display("   actual ins=%0d fail=%0d slot=%0d probes=%0d", got.ins,
						got.fail, got.slot, got.probes);
					$display("   match=%0d tot=%0d icnt=%0d fcnt=%0d", got.match,
						got.tot, got.icnt, got.fcnt);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog expired at %t", $realtime);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Response stall pattern: the stall density is redrawn at random from four levels.
	always @(negedge clk) begin
		int cyc;
		cyc = cyc + 1;
		if (cyc % 200 == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end
		rsp_stall = ($urandom_range(0, 99) < stall_pct);
	end

	// Sender burst state.
	int burst_left = 0;

	// Drives one request and waits for its transfer, then records the result.
	task automatic send_request(logic [1:0] c, logic [30:0] k, logic [9:0] idx,
			bit typed, table_result_t typed_res);
		table_result_t r;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			req_valid = 0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		cmd = c;
		key = k;
		slot_index = idx;
		req_valid = 1;
		do @(posedge clk); while (req_stall);
		r = apply_command(c, k, idx);
		pending_q.push_back(typed ? typed_res : r);
		case (c)
			oahi_pkg::CMD_INSERT: if (r.ins) n_ins++; else n_fail++;
			oahi_pkg::CMD_CLEAR: n_clr++;
			oahi_pkg::CMD_CHECK: n_chk++;
			default: ;
		endcase
		@(negedge clk);
		if (burst_left == 0) req_valid = 0;
	endtask

	// Holds off until the block has returned every expected result.
	task automatic drain();
		req_valid = 0;
		burst_left = 0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Register write over the configuration port, setup then access cycle.
	task automatic write_reg(oahi_pkg::reg_idx_t r, logic [31:0] v);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = oahi_pkg::ADDR_W'({r, 2'b00});
		pwdata = v;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		case (r)
			oahi_pkg::REG_PROBE_MODE: m_mode = v[1:0];
			oahi_pkg::REG_TABLE_SIZE: m_size = v[10:0];
			default: m_prime = v[9:0];
		endcase
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	function automatic logic [30:0] pick_key(longint size);
		case ($urandom_range(0, 5))
			0: return 31'($urandom());
			1: return 31'(32'h7FFF_FFFF - $urandom_range(0, 3));
			2: return 31'(size * $urandom_range(0, 50000) + $urandom_range(0, 3));
			default: return 31'($urandom_range(0, 4 * int'(size) + 4));
		endcase
	endfunction

	dir_row_t dir_rows[$];

	function automatic table_result_t tr(bit i, bit f, int s, int p, bit m,
			int t, int ic, int fc);
		return {i, f, 10'(s), 11'(p), m, 32'(t), 32'(ic), 32'(fc)};
	endfunction

	initial begin
		int phases[][4];
		int size_eff, idx, n;
		logic [1:0] c;
		logic [30:0] k;

		// Directed rows under the reset settings: linear, 1021 slots.
		dir_rows = '{
			'{oahi_pkg::CMD_INSERT, 31'd0, 10'd0, 1, tr(1, 0, 0, 1, 0, 1, 1, 0)},
			'{oahi_pkg::CMD_INSERT, 31'd1021, 10'd0, 1, tr(1, 0, 1, 2, 0, 3, 2, 0)},
			'{oahi_pkg::CMD_CHECK, 31'd0, 10'd0, 1, tr(0, 0, 0, 0, 1, 3, 2, 0)},
			'{oahi_pkg::CMD_CHECK, 31'd0, 10'd1, 1, tr(0, 0, 0, 0, 0, 3, 2, 0)},
			'{oahi_pkg::CMD_CHECK, 31'h7FFF_FFFF, 10'd1023, 1,
				tr(0, 0, 0, 0, 0, 3, 2, 0)},
			'{CMD_IGNORED, 31'h7FFF_FFFF, 10'h3FF, 1, tr(0, 0, 0, 0, 0, 3, 2, 0)},
			'{oahi_pkg::CMD_INSERT, 31'h7FFF_FFFF, 10'd0, 0, '0},
			'{oahi_pkg::CMD_INSERT, 31'd2042, 10'd0, 1, tr(1, 0, 2, 3, 0, 7, 4, 0)},
			'{oahi_pkg::CMD_INSERT, 31'd1020, 10'd0, 1, tr(1, 0, 1020, 1, 0, 8, 5, 0)},
			// Wraps from the last slot in use back to the start.
			'{oahi_pkg::CMD_INSERT, 31'd2041, 10'd0, 1, tr(1, 0, 3, 5, 0, 13, 6, 0)},
			'{oahi_pkg::CMD_CHECK, 31'd2041, 10'd3, 1, tr(0, 0, 0, 0, 1, 13, 6, 0)},
			'{oahi_pkg::CMD_CHECK, 31'h7FFF_FFFF, 10'd53, 0, '0},
			'{oahi_pkg::CMD_CLEAR, 31'd0, 10'd0, 1, tr(0, 0, 0, 0, 0, 0, 0, 0)},
			'{oahi_pkg::CMD_CHECK, 31'd0, 10'd0, 1, tr(0, 0, 0, 0, 0, 0, 0, 0)},
			'{oahi_pkg::CMD_INSERT, 31'd5, 10'd0, 1, tr(1, 0, 5, 1, 0, 1, 1, 0)}
		};
		// Random phases: mode, table size, second prime, item count.
		phases = '{
			'{0, 7, 5, 150}, '{1, 16, 13, 150}, '{2, 13, 11, 150},
			'{2, 8, 0, 100}, '{3, 0, 0, 60}, '{1, 1024, 1023, 80},
			'{2, 2047, 1021, 60}, '{0, 31, 29, 150}, '{1, 11, 7, 150},
			'{2, 1, 0, 50}, '{0, 1021, 1019, 200}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (dir_rows[i])
			send_request(dir_rows[i].c, dir_rows[i].k, dir_rows[i].idx,
				dir_rows[i].typed, dir_rows[i].res);

		foreach (phases[p]) begin
			drain();
			write_reg(oahi_pkg::REG_PROBE_MODE, phases[p][0]);
			write_reg(oahi_pkg::REG_TABLE_SIZE, phases[p][1]);
			write_reg(oahi_pkg::REG_SECOND_PRIME, phases[p][2]);
			size_eff = (phases[p][1] == 0) ? 1 : (phases[p][1] > SLOTS) ? SLOTS
				: phases[p][1];
			n = phases[p][3];
			send_request(oahi_pkg::CMD_CLEAR, 31'd0, 10'd0, 0, '0);
			for (int i = 0; i < n; i++) begin
				k = pick_key(size_eff);
				idx = $urandom_range(0, 99) < 60 ? $urandom_range(0, size_eff - 1)
					: $urandom_range(0, SLOTS - 1);
				case ($urandom_range(0, 99)) inside
					[0:67]: c = oahi_pkg::CMD_INSERT;
					[68:91]: begin
						c = oahi_pkg::CMD_CHECK;
						if (m_valid[idx] && $urandom_range(0, 1)) k = m_keys[idx];
					end
					[92:95]: c = oahi_pkg::CMD_CLEAR;
					default: c = CMD_IGNORED;
				endcase
				send_request(c, k, 10'(idx), 0, '0);
			end
		end

		drain();
		repeat (50) @(negedge clk);
		$display("Covered %0d inserts, %0d failed inserts, %0d checks, %0d clears",
			n_ins, n_fail, n_chk, n_clr);
		$display("over all probe modes, table sizes 0..2047 and second primes 0..1023.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/oahi_pkg.sv
src/oahi_ram.sv
src/oahi_mod.sv
src/oahi_dp.sv
src/oahi_ctrl.sv
src/open_addressing_hash_insert.sv
bench/tb_top.sv
